// ===== rtl/core/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Shared widths, round constants, round helper functions and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package md5_pkg;

   localparam int WORD_W      = 32;
   localparam int BLOCK_WORDS = 16;
   localparam int CHAIN_WORDS = 4;
   localparam int ROUNDS      = 64;
   localparam int ROUND_W     = $clog2(ROUNDS);
   localparam int POS_W       = 6;
   localparam int LEN_W       = 64;

   localparam logic [ROUND_W-1:0] LAST_ROUND    = ROUND_W'(ROUNDS - 1);
   localparam logic [POS_W-1:0]   LAST_BYTE_POS = POS_W'(63);
   localparam logic [POS_W-1:0]   LEN_BYTE_POS  = POS_W'(56);
   localparam logic [7:0]         PAD_BYTE      = 8'h80;

   localparam logic [WORD_W-1:0] CHAIN_IV [CHAIN_WORDS] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [WORD_W-1:0] ROUND_CONST [ROUNDS] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   typedef struct packed {
      logic               load_byte;
      logic               pad;
      logic               len;
      logic               init;
      logic               round;
      logic               add_back;
      logic               emit;
      logic [ROUND_W-1:0] round_idx;
   } md5_cmd_type;

   typedef struct packed {
      logic [POS_W-1:0] byte_pos;
      logic             pad_fits;
   } md5_stat_type;

   // Message word used by a round
   function automatic logic [3:0] msg_index(input logic [ROUND_W-1:0] i);
      logic [3:0] j;
      logic [3:0] r;
      j = i[3:0];
      case (i[5:4])
         2'd0:    r = j;
         2'd1:    r = 4'(5 * j + 1);
         2'd2:    r = 4'(3 * j + 5);
         2'd3:    r = 4'(7 * j);
         default: r = j;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [ROUND_W-1:0] i);
      logic [4:0] s;
      case ({i[5:4], i[1:0]})
         4'd0:    s = 5'd7;
         4'd1:    s = 5'd12;
         4'd2:    s = 5'd17;
         4'd3:    s = 5'd22;
         4'd4:    s = 5'd5;
         4'd5:    s = 5'd9;
         4'd6:    s = 5'd14;
         4'd7:    s = 5'd20;
         4'd8:    s = 5'd4;
         4'd9:    s = 5'd11;
         4'd10:   s = 5'd16;
         4'd11:   s = 5'd23;
         4'd12:   s = 5'd6;
         4'd13:   s = 5'd10;
         4'd14:   s = 5'd15;
         4'd15:   s = 5'd21;
         default: s = 5'd7;
      endcase
      return s;
   endfunction

   function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                               input logic [4:0] s);
      logic [2*WORD_W-1:0] dbl;
      dbl = {v, v} << s;
      return dbl[2*WORD_W-1:WORD_W];
   endfunction

   function automatic logic [WORD_W-1:0] bswap32(input logic [WORD_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== rtl/core/md5_datapath.sv =====
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, bit length, chaining words, one shared round unit and the
// digest output register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module md5_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  md5_pkg::md5_cmd_type cmd,
   output md5_pkg::md5_stat_type stat,
   input  logic [7:0]           req_data_byte,
   output logic [63:0]          rsp_digest_hi,
   output logic [63:0]          rsp_digest_lo
);
   import md5_pkg::*;

   logic [WORD_W-1:0] block_ff [BLOCK_WORDS];
   logic [WORD_W-1:0] block_in [BLOCK_WORDS];
   logic [WORD_W-1:0] chain_ff [CHAIN_WORDS];
   logic [WORD_W-1:0] chain_in [CHAIN_WORDS];
   logic [LEN_W-1:0]  bit_len_ff, bit_len_in;
   logic [WORD_W-1:0] a_ff, b_ff, c_ff, d_ff;
   logic [WORD_W-1:0] a_in, b_in, c_in, d_in;
   logic [WORD_W-1:0] pre_ff, pre_in;
   logic [63:0]       dig_hi_ff, dig_lo_ff, dig_hi_in, dig_lo_in;

   logic [POS_W-1:0]   byte_pos;
   logic               pad_fits;
   logic [WORD_W-1:0]  func_val;
   logic [WORD_W-1:0]  round_sum;
   logic [WORD_W-1:0]  b_next;
   logic [ROUND_W-1:0] next_round;
   logic [WORD_W-1:0]  pre_base;

   assign byte_pos = bit_len_ff[8:3];
   assign pad_fits = byte_pos < LEN_BYTE_POS;
   assign stat.byte_pos = byte_pos;
   assign stat.pad_fits = pad_fits;

   // Block buffer: byte load, pad fill, or length block
   always_comb begin
      block_in = block_ff;
      if (cmd.load_byte) begin
         block_in[byte_pos[5:2]][8*byte_pos[1:0] +: 8] = req_data_byte;
      end else if (cmd.pad) begin
         for (int w = 0; w < BLOCK_WORDS; w++) begin
            for (int l = 0; l < 4; l++) begin
               if (POS_W'(4*w + l) == byte_pos) begin
                  block_in[w][8*l +: 8] = PAD_BYTE;
               end else if (POS_W'(4*w + l) > byte_pos) begin
                  block_in[w][8*l +: 8] = 8'h00;
               end
            end
         end
         if (pad_fits) begin
            block_in[BLOCK_WORDS-2] = bit_len_ff[WORD_W-1:0];
            block_in[BLOCK_WORDS-1] = bit_len_ff[LEN_W-1:WORD_W];
         end
      end else if (cmd.len) begin
         for (int w = 0; w < BLOCK_WORDS - 2; w++) begin
            block_in[w] = '0;
         end
         block_in[BLOCK_WORDS-2] = bit_len_ff[WORD_W-1:0];
         block_in[BLOCK_WORDS-1] = bit_len_ff[LEN_W-1:WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   // Round unit; pre_ff carries a + K + M for the round in progress
   always_comb begin
      case (cmd.round_idx[5:4])
         2'd0:    func_val = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1:    func_val = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2:    func_val = b_ff ^ c_ff ^ d_ff;
         2'd3:    func_val = c_ff ^ (b_ff | ~d_ff);
         default: func_val = b_ff ^ c_ff ^ d_ff;
      endcase
      round_sum  = pre_ff + func_val;
      b_next     = b_ff + rotl32(round_sum, rot_amount(cmd.round_idx));
      next_round = cmd.init ? '0 : ROUND_W'(cmd.round_idx + 1'b1);
      pre_base   = cmd.init ? chain_ff[0] : d_ff;
      pre_in     = pre_base + ROUND_CONST[next_round] + block_ff[msg_index(next_round)];

      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      d_in = d_ff;
      if (cmd.init) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
      end else if (cmd.round) begin
         a_in = d_ff;
         b_in = b_next;
         c_in = b_ff;
         d_in = c_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      pre_ff <= pre_in;
   end

   // Chaining words and length; both return to reset values after a digest
   always_comb begin
      chain_in   = chain_ff;
      bit_len_in = bit_len_ff;
      if (cmd.add_back) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
      end else if (cmd.emit) begin
         chain_in = CHAIN_IV;
      end
      if (cmd.load_byte) begin
         bit_len_in = bit_len_ff + LEN_W'(8);
      end else if (cmd.emit) begin
         bit_len_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff   <= CHAIN_IV;
         bit_len_ff <= '0;
      end else begin
         chain_ff   <= chain_in;
         bit_len_ff <= bit_len_in;
      end
   end

   // Digest output register
   always_comb begin
      dig_hi_in = dig_hi_ff;
      dig_lo_in = dig_lo_ff;
      if (cmd.emit) begin
         dig_hi_in = {bswap32(chain_ff[0]), bswap32(chain_ff[1])};
         dig_lo_in = {bswap32(chain_ff[2]), bswap32(chain_ff[3])};
      end
   end

   always_ff @(posedge clock) begin
      dig_hi_ff <= dig_hi_in;
      dig_lo_ff <= dig_lo_in;
   end

   assign rsp_digest_hi = dig_hi_ff;
   assign rsp_digest_lo = dig_lo_ff;

endmodule

// ===== rtl/core/md5_ctrl.sv =====
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte loads, padding, compression rounds and digest output, and
// owns the request and response handshakes.
// ----------------------------------------------------------------------------
module md5_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_has_byte,
   input  logic                  req_end_of_message,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output md5_pkg::md5_cmd_type  cmd,
   input  md5_pkg::md5_stat_type stat
);
   import md5_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_LEN   = 3'd2;
   localparam logic [2:0] S_PRE   = 3'd3;
   localparam logic [2:0] S_ROUND = 3'd4;
   localparam logic [2:0] S_ADD   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic               fin_ff, fin_in;
   logic               padded_ff, padded_in;
   logic               last_ff, last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accept;
   logic               out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      round_in      = round_ff;
      fin_in        = fin_ff;
      padded_in     = padded_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd           = '0;
      cmd.round_idx = round_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_byte = req_has_byte;
               if (req_has_byte && stat.byte_pos == LAST_BYTE_POS) begin
                  fin_in   = req_end_of_message;
                  state_in = S_PRE;
               end else if (req_end_of_message) begin
                  state_in = S_PAD;
               end
            end
         end
         S_PAD: begin
            cmd.pad   = 1'b1;
            padded_in = 1'b1;
            fin_in    = 1'b0;
            last_in   = stat.pad_fits;
            state_in  = S_PRE;
         end
         S_LEN: begin
            cmd.len  = 1'b1;
            last_in  = 1'b1;
            state_in = S_PRE;
         end
         S_PRE: begin
            cmd.init = 1'b1;
            round_in = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.round = 1'b1;
            round_in  = ROUND_W'(round_ff + 1'b1);
            if (round_ff == LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.add_back = 1'b1;
            if (last_ff) begin
               state_in = S_OUT;
            end else if (padded_ff) begin
               state_in = S_LEN;
            end else if (fin_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               fin_in       = 1'b0;
               padded_in    = 1'b0;
               last_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         round_ff     <= '0;
         fin_ff       <= 1'b0;
         padded_ff    <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         fin_ff       <= fin_in;
         padded_ff    <= padded_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_pre_starts_round0: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PRE |=> (state_ff == S_ROUND && round_ff == '0))
      else $error("compression did not start at round zero");

   a_last_round_adds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == LAST_ROUND) |=> state_ff == S_ADD)
      else $error("last round not followed by add-back");

   a_out_only_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_OUT |-> (last_ff && padded_ff))
      else $error("digest stage reached before final block");

   a_emit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && state_ff == S_IDLE && !last_ff))
      else $error("digest emit did not raise response valid");

endmodule

// ===== rtl/core/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 hash with a controller and a single-round datapath.
// ----------------------------------------------------------------------------
// Byte item: one byte is loaded; the byte that fills a 64-byte block also runs
//   setup, 64 rounds on the one round unit, and add-back.
// End item: pad, compression, and a length block with its compression when the
//   pad spills, then the output register. req_stall is high while not idle.
// Reset: synchronous; chaining words return to the MD5 initial values and the
//   length to zero, as they also do after every digest.
module md5_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest_hi,
   output logic [63:0] rsp_digest_lo
);
   import md5_pkg::*;

   md5_cmd_type  cmd;
   md5_stat_type stat;

   md5_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_has_byte       (req_has_byte),
      .req_end_of_message (req_end_of_message),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .cmd                (cmd),
      .stat               (stat)
   );

   md5_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_data_byte (req_data_byte),
      .rsp_digest_hi (rsp_digest_hi),
      .rsp_digest_lo (rsp_digest_lo)
   );

endmodule
